FILE: sv/okq_pkg.sv
// okq_pkg: sizes, codes and shared types of the ordered key queue.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none

package okq_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_WIDTH  = 32;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_INSERT      = 3'd0,
      OP_REMOVE_HEAD = 3'd1,
      OP_REMOVE_KEY  = 3'd2,
      OP_GET_KEY     = 3'd3,
      OP_PEEK        = 3'd4,
      OP_STATUS      = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_NOT_EMPTY = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_FIFO     = 2'd0,
      MODE_SIGNED   = 2'd1,
      MODE_UNSIGNED = 2'd2
   } mode_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   // what a cell does on the update edge
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_kind_type;

   // which per-cell flag drives the position chain
   typedef enum logic [1:0] {
      SEL_AFTER = 2'd0,
      SEL_OCC   = 2'd1,
      SEL_MATCH = 2'd2
   } cell_sel_type;

   typedef struct packed {
      cell_kind_type kind;
      cell_sel_type  sel;
   } cell_cmd_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]  key;
      logic [DATA_WIDTH-1:0] data;
   } entry_type;

endpackage

`default_nettype wire

FILE: sv/okq_if.sv
// okq_req_if and okq_rsp_if: valid/ready channels of the ordered key queue.
// Depends on okq_pkg for field widths and codes.
`default_nettype none

interface okq_req_if;
   logic                            valid;
   logic                            ready;
   okq_pkg::op_type                 op;
   logic [okq_pkg::KEY_WIDTH-1:0]   key_in;
   logic [okq_pkg::DATA_WIDTH-1:0]  data_in;

   modport source (output valid, output op, output key_in, output data_in, input ready);
   modport sink   (input valid, input op, input key_in, input data_in, output ready);
endinterface

interface okq_rsp_if;
   logic                            valid;
   logic                            ready;
   okq_pkg::status_type             status;
   logic [okq_pkg::DATA_WIDTH-1:0]  data_out;
   logic [okq_pkg::KEY_WIDTH-1:0]   key_out;

   modport source (output valid, output status, output data_out, output key_out, input ready);
   modport sink   (input valid, input status, input data_out, input key_out, output ready);
endinterface

`default_nettype wire

FILE: sv/okq_cell.sv
// okq_cell: one slot of the ordered store; holds a key and data word, compares
// the key against the search key and shifts with its neighbours. Uses okq_pkg.
`default_nettype none

module okq_cell (
   input  wire                              clock,
   input  wire                              capture,
   input  wire [okq_pkg::KEY_WIDTH-1:0]     search_key,
   input  wire                              cmp_ordered,
   input  wire                              cmp_signed,
   input  wire                              occ,
   input  okq_pkg::cell_cmd_type            cmd,
   input  wire                              ge_in,
   output logic                             ge_out,
   input  wire [okq_pkg::DATA_WIDTH-1:0]    hit_in,
   output logic [okq_pkg::DATA_WIDTH-1:0]   hit_out,
   input  okq_pkg::entry_type               prev_entry,
   input  okq_pkg::entry_type               next_entry,
   input  okq_pkg::entry_type               new_entry,
   output okq_pkg::entry_type               entry
);

   okq_pkg::entry_type entry_ff, entry_in;
   logic               after_ff, after_in;
   logic               match_ff, match_in;
   logic               flag;
   logic               first;

   always_comb begin
      if (cmp_signed) begin
         after_in = cmp_ordered && ($signed(entry_ff.key) > $signed(search_key));
      end else begin
         after_in = cmp_ordered && (entry_ff.key > search_key);
      end
      match_in = (entry_ff.key == search_key);
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         after_ff <= after_in;
         match_ff <= match_in;
      end
      entry_ff <= entry_in;
   end

   always_comb begin
      unique case (cmd.sel)
         okq_pkg::SEL_AFTER: flag = after_ff || !occ;
         okq_pkg::SEL_OCC:   flag = occ;
         okq_pkg::SEL_MATCH: flag = match_ff && occ;
         default:            flag = 1'b0;
      endcase
   end

   // ge marks the chosen slot and everything behind it
   assign ge_out  = ge_in | flag;
   assign first   = ge_out & ~ge_in;
   assign hit_out = hit_in | (first ? entry_ff.data : '0);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.kind)
         okq_pkg::CELL_INSERT: begin
            if (ge_in) begin
               entry_in = prev_entry;
            end else if (ge_out) begin
               entry_in = new_entry;
            end
         end
         okq_pkg::CELL_REMOVE: begin
            if (ge_out) begin
               entry_in = next_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/ordered_key_queue_core.sv
// ordered_key_queue_core: DEPTH-entry key/data store kept in key order or
// arrival order, built as a shifting row of okq_cell. Uses okq_pkg, okq_if.
//
// Use:
//   req_chan carries one operation per beat (insert, remove head, remove or
//   get by key, peek, status); rsp_chan returns exactly one result beat per
//   request. csr_we/csr_wdata set the ordering mode, written while empty.
// Timing:
//   a request is taken in the idle state, when every cell compares its key
//   against the request key; the update state then resolves the first hit
//   through the cell chain, shifts the row and loads the result register.
//   A new request is taken only once that update is done, so the row of
//   cells is busy for both states.
// Stalls:
//   req_chan.ready is high in the idle cycle even while a result waits, so
//   the next request is taken; its update then holds until rsp_chan.ready
//   frees the result register.
// Reset:
//   empties the store and selects fifo mode; cell contents are not cleared,
//   only the fill count marks which cells hold entries.
`default_nettype none

module ordered_key_queue_core (
   input  wire              clock,
   input  wire              reset,
   okq_req_if.sink          req_chan,
   okq_rsp_if.source        rsp_chan,
   input  wire              csr_we,
   input  wire [1:0]        csr_wdata
);

   okq_pkg::state_type                 state_ff, state_in;
   logic [okq_pkg::CNT_WIDTH-1:0]      count_ff, count_in;
   okq_pkg::mode_type                  mode_ff;
   okq_pkg::op_type                    op_ff;
   okq_pkg::entry_type                 new_entry_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   okq_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [okq_pkg::DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   logic [okq_pkg::KEY_WIDTH-1:0]      rsp_key_ff, rsp_key_in;

   okq_pkg::cell_cmd_type              cmd;
   logic                               capture;
   logic                               done;
   logic                               is_empty, is_full;
   logic                               cmp_ordered, cmp_signed;

   okq_pkg::entry_type                 entry_w [okq_pkg::DEPTH];
   logic                               ge_w    [okq_pkg::DEPTH+1];
   logic [okq_pkg::DATA_WIDTH-1:0]     hit_w   [okq_pkg::DEPTH+1];

   assign capture     = (state_ff == okq_pkg::ST_IDLE);
   assign cmp_signed  = (mode_ff == okq_pkg::MODE_SIGNED);
   assign cmp_ordered = (mode_ff == okq_pkg::MODE_SIGNED) ||
                        (mode_ff == okq_pkg::MODE_UNSIGNED);
   assign is_empty    = (count_ff == '0);
   assign is_full     = (count_ff == okq_pkg::CNT_WIDTH'(okq_pkg::DEPTH));

   assign ge_w[0]  = 1'b0;
   assign hit_w[0] = '0;

   for (genvar i = 0; i < okq_pkg::DEPTH; i++) begin : g_cell
      localparam int Prev = (i == 0) ? 0 : i - 1;
      localparam int Next = (i == okq_pkg::DEPTH - 1) ? i : i + 1;
      logic occ;
      assign occ = (okq_pkg::CNT_WIDTH'(i) < count_ff);

      okq_cell u_cell (
         .clock       (clock),
         .capture     (capture),
         .search_key  (req_chan.key_in),
         .cmp_ordered (cmp_ordered),
         .cmp_signed  (cmp_signed),
         .occ         (occ),
         .cmd         (cmd),
         .ge_in       (ge_w[i]),
         .ge_out      (ge_w[i+1]),
         .hit_in      (hit_w[i]),
         .hit_out     (hit_w[i+1]),
         .prev_entry  (entry_w[Prev]),
         .next_entry  (entry_w[Next]),
         .new_entry   (new_entry_ff),
         .entry       (entry_w[i])
      );
   end

   assign req_chan.ready    = (state_ff == okq_pkg::ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.data_out = rsp_data_ff;
   assign rsp_chan.key_out  = rsp_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= okq_pkg::ST_IDLE;
         count_ff     <= '0;
         mode_ff      <= okq_pkg::MODE_FIFO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            mode_ff <= okq_pkg::mode_type'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         op_ff             <= req_chan.op;
         new_entry_ff.key  <= req_chan.key_in;
         new_entry_ff.data <= req_chan.data_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_key_ff    <= rsp_key_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_key_in    = rsp_key_ff;
      cmd.kind      = okq_pkg::CELL_HOLD;
      cmd.sel       = okq_pkg::SEL_MATCH;
      done          = 1'b0;

      unique case (state_ff)
         okq_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = okq_pkg::ST_UPDATE;
            end
         end
         okq_pkg::ST_UPDATE: begin
            done = !rsp_valid_ff || rsp_chan.ready;
         end
         default: state_in = okq_pkg::ST_IDLE;
      endcase

      if (done) begin
         state_in      = okq_pkg::ST_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = okq_pkg::STS_OK;
         rsp_data_in   = '0;
         rsp_key_in    = '0;
         unique case (op_ff)
            okq_pkg::OP_INSERT: begin
               cmd.sel = okq_pkg::SEL_AFTER;
               if (is_full) begin
                  rsp_status_in = okq_pkg::STS_FULL;
               end else begin
                  cmd.kind = okq_pkg::CELL_INSERT;
                  count_in = count_ff + okq_pkg::CNT_WIDTH'(1);
               end
            end
            okq_pkg::OP_REMOVE_HEAD: begin
               cmd.sel = okq_pkg::SEL_OCC;
               if (is_empty) begin
                  rsp_status_in = okq_pkg::STS_EMPTY;
               end else begin
                  cmd.kind    = okq_pkg::CELL_REMOVE;
                  rsp_data_in = hit_w[okq_pkg::DEPTH];
                  count_in    = count_ff - okq_pkg::CNT_WIDTH'(1);
               end
            end
            okq_pkg::OP_REMOVE_KEY, okq_pkg::OP_GET_KEY: begin
               cmd.sel = okq_pkg::SEL_MATCH;
               // a miss leaves the chain clear, so remove shifts nothing
               if (op_ff == okq_pkg::OP_REMOVE_KEY) begin
                  cmd.kind = okq_pkg::CELL_REMOVE;
               end
               if (is_empty) begin
                  rsp_status_in = okq_pkg::STS_EMPTY;
               end else if (!ge_w[okq_pkg::DEPTH]) begin
                  rsp_status_in = okq_pkg::STS_NOT_FOUND;
               end else begin
                  rsp_data_in = hit_w[okq_pkg::DEPTH];
                  if (op_ff == okq_pkg::OP_REMOVE_KEY) begin
                     count_in = count_ff - okq_pkg::CNT_WIDTH'(1);
                  end
               end
            end
            okq_pkg::OP_PEEK: begin
               if (is_empty) begin
                  rsp_status_in = okq_pkg::STS_EMPTY;
               end else begin
                  rsp_key_in = entry_w[0].key;
               end
            end
            default: begin
               rsp_status_in = is_empty ? okq_pkg::STS_EMPTY : okq_pkg::STS_NOT_EMPTY;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: sv/okq_checker.sv
// okq_checker: port-level assertions on ordered_key_queue_core, attached by
// the bind at the end of this file. Uses okq_pkg for the status codes.
`default_nettype none

module okq_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_ready,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  okq_pkg::status_type              rsp_status,
   input  wire [okq_pkg::DATA_WIDTH-1:0]    rsp_data_out,
   input  wire [okq_pkg::KEY_WIDTH-1:0]     rsp_key_out
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_data_out) && $stable(rsp_key_out))
      else $error("result beat changed while stalled");

   // one request in flight: the cycle after a beat is busy
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // with the result register free, the update does not stall and the answer follows it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid)
      else $error("result beat missing two cycles after request");

   // payload fields are zero unless the operation succeeded
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != okq_pkg::STS_OK) |->
      (rsp_data_out == '0) && (rsp_key_out == '0))
      else $error("non-zero payload on a failed operation");

endmodule

bind ordered_key_queue_core okq_checker u_okq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_data_out (rsp_chan.data_out),
   .rsp_key_out  (rsp_chan.key_out)
);

`default_nettype wire

FILE: tb/okq_order_checker.sv
// okq_order_checker: watches the request, result and csr ports of the ordered key queue,
// keeps its own copy of the store and compares every result beat with its prediction.
// Depends on okq_pkg and the okq_req_if / okq_rsp_if interfaces.
module okq_order_checker (
   input  wire        clock,
   input  wire        reset,
   okq_req_if         req_mon,
   okq_rsp_if         rsp_mon,
   input  wire        csr_we,
   input  wire [1:0]  csr_wdata,
   output int         fail_count,
   output int         backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      okq_pkg::status_type            status;
      logic [okq_pkg::DATA_WIDTH-1:0] data;
      logic [okq_pkg::KEY_WIDTH-1:0]  key;
   } queue_result_type;

   logic [okq_pkg::KEY_WIDTH-1:0]  model_keys [okq_pkg::DEPTH];
   logic [okq_pkg::DATA_WIDTH-1:0] model_data [okq_pkg::DEPTH];
   int unsigned                    model_fill = 0;
   logic [1:0]                     model_mode = okq_pkg::MODE_FIFO;
   queue_result_type               expected_results [$];
   int                             n_fail = 0;

   // stored key sorts strictly behind the incoming one
   function automatic logic key_after(logic [okq_pkg::KEY_WIDTH-1:0] stored,
                                      logic [okq_pkg::KEY_WIDTH-1:0] incoming);
      if (model_mode == okq_pkg::MODE_SIGNED)
         return $signed(stored) > $signed(incoming);
      return stored > incoming;
   endfunction

   function automatic void drop_entry(int unsigned pos);
      for (int unsigned i = pos; i + 1 < model_fill; i++) begin
         model_keys[i] = model_keys[i + 1];
         model_data[i] = model_data[i + 1];
      end
      model_fill--;
   endfunction

   function automatic queue_result_type predict_queue_op(
         logic [2:0] code,
         logic [okq_pkg::KEY_WIDTH-1:0] key,
         logic [okq_pkg::DATA_WIDTH-1:0] data);
      queue_result_type res;
      int unsigned      pos;
      res.status = okq_pkg::STS_OK;
      res.data = '0;
      res.key = '0;
      case (code)
         okq_pkg::OP_INSERT: begin
            if (model_fill >= okq_pkg::DEPTH) begin
               res.status = okq_pkg::STS_FULL;
            end else begin
               pos = model_fill;
               // mode 3 falls back to plain append
               if (model_mode == okq_pkg::MODE_SIGNED ||
                   model_mode == okq_pkg::MODE_UNSIGNED) begin
                  for (int unsigned i = 0; i < model_fill; i++) begin
                     if (key_after(model_keys[i], key)) begin
                        pos = i;
                        break;
                     end
                  end
               end
               for (int unsigned i = model_fill; i > pos; i--) begin
                  model_keys[i] = model_keys[i - 1];
                  model_data[i] = model_data[i - 1];
               end
               model_keys[pos] = key;
               model_data[pos] = data;
               model_fill++;
            end
         end
         okq_pkg::OP_REMOVE_HEAD: begin
            if (model_fill == 0) begin
               res.status = okq_pkg::STS_EMPTY;
            end else begin
               res.data = model_data[0];
               drop_entry(0);
            end
         end
         okq_pkg::OP_REMOVE_KEY, okq_pkg::OP_GET_KEY: begin
            if (model_fill == 0) begin
               res.status = okq_pkg::STS_EMPTY;
            end else begin
               pos = model_fill;
               for (int unsigned i = 0; i < model_fill; i++) begin
                  if (model_keys[i] == key) begin
                     pos = i;
                     break;
                  end
               end
               if (pos == model_fill) begin
                  res.status = okq_pkg::STS_NOT_FOUND;
               end else begin
                  res.data = model_data[pos];
                  if (code == okq_pkg::OP_REMOVE_KEY)
                     drop_entry(pos);
               end
            end
         end
         okq_pkg::OP_PEEK: begin
            if (model_fill == 0)
               res.status = okq_pkg::STS_EMPTY;
            else
               res.key = model_keys[0];
         end
         // status and the two unused codes
         default: res.status = (model_fill == 0) ? okq_pkg::STS_EMPTY
                                                 : okq_pkg::STS_NOT_EMPTY;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      queue_result_type want;
      if (reset) begin
         model_fill = 0;
         model_mode = okq_pkg::MODE_FIFO;
         expected_results.delete();
      end else begin
         // result side first: a beat accepted now belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with nothing outstanding: status %0d data %h key %h",
                      rsp_mon.status, rsp_mon.data_out, rsp_mon.key_out);
               n_fail++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  n_fail++;
               end
               if (rsp_mon.data_out !== want.data) begin
                  $error("data_out: expected %h, got %h", want.data, rsp_mon.data_out);
                  n_fail++;
               end
               if (rsp_mon.key_out !== want.key) begin
                  $error("key_out: expected %h, got %h", want.key, rsp_mon.key_out);
                  n_fail++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(predict_queue_op(req_mon.op, req_mon.key_in,
                                                        req_mon.data_in));
         if (csr_we)
            model_mode = csr_wdata;
      end
      fail_count <= n_fail;
      backlog <= expected_results.size();
   end

endmodule

FILE: tb/ordered_key_queue_core_tb.sv
// ordered_key_queue_core_tb: drives requests, result back-pressure and mode writes
// into ordered_key_queue_core and gives the verdict from okq_order_checker.
// Depends on okq_pkg, okq_req_if / okq_rsp_if and okq_order_checker.
module ordered_key_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_SPARE  = 2'd3;
   localparam logic [2:0] OP_RSVD_LO  = 3'd6;
   localparam logic [2:0] OP_RSVD_HI  = 3'd7;
   localparam int         ITEM_TARGET = 1500;

   typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_wdata;
   logic       steady = 1'b0;
   int         fail_count;
   int         backlog;

   okq_req_if req_chan();
   okq_rsp_if rsp_chan();

   ordered_key_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   okq_order_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   always #10 clock = ~clock;

   initial begin : watchdog
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_beat(logic [2:0] code, logic [okq_pkg::KEY_WIDTH-1:0] key,
                            logic [okq_pkg::DATA_WIDTH-1:0] data);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.op      <= okq_pkg::op_type'(code);
      req_chan.key_in  <= key;
      req_chan.data_in <= data;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold requests back until every result beat has been taken
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_order(logic [1:0] mode);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly a small pool of near-zero keys of both signs so searches hit
   function automatic logic [okq_pkg::KEY_WIDTH-1:0] pick_key();
      logic [okq_pkg::KEY_WIDTH-1:0] k;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: k = 32'h0000_0000;
               1: k = 32'h0000_0001;
               2: k = 32'h7FFF_FFFF;
               3: k = 32'h8000_0000;
               default: k = 32'hFFFF_FFFF;
            endcase
         end
         1, 2: k = $urandom;
         default: begin
            k = $urandom_range(0, 7);
            if ($urandom_range(0, 1))
               k = -k;
         end
      endcase
      return k;
   endfunction

   function automatic logic [2:0] pick_op(phase_type kind);
      int r;
      int ins;
      ins = (kind == PH_FILL) ? 85 : (kind == PH_MIXED) ? 40 : 10;
      if ($urandom_range(0, 99) < ins)
         return okq_pkg::OP_INSERT;
      r = $urandom_range(0, 99);
      if (r < 40) return okq_pkg::OP_REMOVE_HEAD;
      if (r < 60) return okq_pkg::OP_REMOVE_KEY;
      if (r < 75) return okq_pkg::OP_GET_KEY;
      if (r < 88) return okq_pkg::OP_PEEK;
      r = $urandom_range(0, 2);
      return (r == 0) ? okq_pkg::OP_STATUS : (r == 1) ? OP_RSVD_LO : OP_RSVD_HI;
   endfunction

   // result side back-pressure
   initial begin : rsp_pacing
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin : stimulus
      int         total;
      int         span;
      int         p;
      int         spins;
      phase_type  kind;
      logic [1:0] mode_plan [4];
      mode_plan = '{okq_pkg::MODE_FIFO, okq_pkg::MODE_SIGNED, okq_pkg::MODE_UNSIGNED,
                    MODE_SPARE};
      req_chan.valid   <= 1'b0;
      req_chan.op      <= okq_pkg::OP_STATUS;
      req_chan.key_in  <= '0;
      req_chan.data_in <= '0;
      csr_we           <= 1'b0;
      csr_wdata        <= okq_pkg::MODE_FIFO;
      reset            <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // every read-type op on an empty store, fifo mode out of reset
      send_beat(okq_pkg::OP_STATUS, '0, '0);
      send_beat(okq_pkg::OP_REMOVE_HEAD, '0, '0);
      send_beat(okq_pkg::OP_PEEK, '0, '0);
      send_beat(okq_pkg::OP_REMOVE_KEY, 32'h0000_0000, '0);
      send_beat(okq_pkg::OP_GET_KEY, 32'hFFFF_FFFF, '0);
      send_beat(OP_RSVD_LO, '0, '0);
      send_beat(OP_RSVD_HI, '0, '0);

      // signed order: extreme keys, duplicate keys keep arrival order
      set_order(okq_pkg::MODE_SIGNED);
      send_beat(okq_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0000);
      send_beat(okq_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_beat(okq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0001);
      send_beat(okq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0002);
      send_beat(okq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0003);
      send_beat(okq_pkg::OP_PEEK, '0, '0);
      send_beat(okq_pkg::OP_GET_KEY, 32'h0000_0000, '0);
      send_beat(okq_pkg::OP_REMOVE_KEY, 32'h0000_0000, '0);
      send_beat(okq_pkg::OP_GET_KEY, 32'h0000_0000, '0);
      send_beat(okq_pkg::OP_GET_KEY, 32'h0001_2345, '0);
      send_beat(okq_pkg::OP_REMOVE_HEAD, '0, '0);
      send_beat(okq_pkg::OP_STATUS, '0, '0);

      // random phases; the store is not emptied between them, so mode
      // changes also land on a partly filled store
      total = 0;
      p = 0;
      while (total < ITEM_TARGET) begin
         kind   = phase_type'(p % 3);
         steady = (p % 4 == 3);
         set_order((p < 4) ? mode_plan[p] : 2'($urandom_range(0, 3)));
         span = $urandom_range(80, 170);
         repeat (span) send_beat(pick_op(kind), pick_key(), $urandom);
         total += span;
         p++;
      end
      steady = 1'b0;

      req_chan.valid <= 1'b0;
      @(posedge clock);
      spins = 0;
      while (backlog != 0 && spins < 1000) begin
         @(posedge clock);
         spins++;
      end
      repeat (6) @(posedge clock);
      if (fail_count == 0 && backlog == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
